// ===== hw/rtl/value_fingerprint_hash_assert.svh =====
// assertion macros shared by the fingerprint hash rtl
`ifndef VALUE_FINGERPRINT_HASH_ASSERT_SVH
`define VALUE_FINGERPRINT_HASH_ASSERT_SVH

// checked only while out of reset
`define VFH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// checked on every edge, reset included
`define VFH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hw/rtl/vfh_pkg.sv =====
// shared types, constants and hash helpers for the value fingerprint hash
package vfh_pkg;

  localparam logic [31:0] FNV_BASIS  = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME  = 32'd16777619;
  localparam logic [30:0] POS_MAX    = 31'h7FFF_FFFF;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  // one classified beat handed from the front to the back
  typedef struct packed {
    logic [7:0]  data;
    logic        head_en;
    logic        tail_en;
    logic        last;
    logic        is_long;
    logic        mismatch;
    logic [31:0] len97;
  } vfh_entry_t;

  function automatic logic [31:0] fnv_step(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] x;
    x = acc ^ {24'd0, b};
    return x * FNV_PRIME;
  endfunction

  // times 97 as 64 + 32 + 1
  function automatic logic [31:0] mul97(input logic [31:0] x);
    return (x << 6) + (x << 5) + x;
  endfunction

endpackage

// ===== hw/rtl/vfh_front.sv =====
// front end: accepts beats, tracks the byte count and picks head or tail
module vfh_front #(
  parameter int unsigned SEGMENT_BYTES = 512
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  input  logic               byte_present_i,
  input  logic [30:0]        value_len_i,
  input  logic               last_byte_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output vfh_pkg::vfh_entry_t q_entry_o
);
  import vfh_pkg::*;

  localparam logic [30:0] SEG     = 31'(SEGMENT_BYTES);
  localparam logic [30:0] TWO_SEG = 31'(2 * SEGMENT_BYTES);

  logic [30:0] pos_q, pos_d, pos_upd;
  logic        ovf_q, ovf_d, ovf_upd;
  logic        accept;
  logic        is_long;
  logic [30:0] tail_start;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign is_long    = value_len_i > TWO_SEG;
  assign tail_start = value_len_i - SEG;

  always_comb begin
    pos_upd = pos_q;
    ovf_upd = ovf_q;
    if (byte_present_i) begin
      if (pos_q == POS_MAX) begin
        ovf_upd = 1'b1;
      end else begin
        pos_upd = pos_q + 31'd1;
      end
    end
  end

  always_comb begin
    pos_d = pos_q;
    ovf_d = ovf_q;
    if (accept) begin
      if (last_byte_i) begin
        pos_d = '0;
        ovf_d = 1'b0;
      end else begin
        pos_d = pos_upd;
        ovf_d = ovf_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      ovf_q <= ovf_d;
    end
  end

  // a beat with no byte that does not end the value is dropped
  assign q_push_o = accept && (byte_present_i || last_byte_i);

  always_comb begin
    q_entry_o.data     = data_byte_i;
    q_entry_o.head_en  = byte_present_i && (!is_long || (pos_q < SEG));
    q_entry_o.tail_en  = byte_present_i && is_long && (pos_q >= tail_start);
    q_entry_o.last     = last_byte_i;
    q_entry_o.is_long  = is_long;
    q_entry_o.mismatch = ovf_upd || (pos_upd != value_len_i);
    q_entry_o.len97    = mul97({1'b0, value_len_i});
  end

endmodule

// ===== hw/rtl/vfh_queue.sv =====
// small queue between front and back
`include "value_fingerprint_hash_assert.svh"

module vfh_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  vfh_pkg::vfh_entry_t entry_i,
  output logic                full_o,
  input  logic                pop_i,
  output vfh_pkg::vfh_entry_t entry_o,
  output logic                empty_o
);
  import vfh_pkg::*;

  vfh_entry_t        mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == QCNT_W'(QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  `VFH_ASSERT(a_cnt_bound, cnt_q <= QCNT_W'(QUEUE_DEPTH), "queue count above depth")
  `VFH_ASSERT(a_cnt_drop, (pop_i && !push_i) |=> (cnt_q == $past(cnt_q) - QCNT_W'(1)),
              "queue count did not drop on pop")
  `VFH_ASSERT_ALWAYS(a_no_overrun, !(push_i && full_o), "push into a full queue")
  `VFH_ASSERT(a_no_underrun, !(pop_i && empty_o), "pop from an empty queue")

endmodule

// ===== hw/rtl/vfh_back.sv =====
// back end: fnv accumulators and the final combine pipeline
`include "value_fingerprint_hash_assert.svh"

module vfh_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  vfh_pkg::vfh_entry_t q_entry_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [31:0]         fingerprint_o,
  output logic                length_mismatch_o
);
  import vfh_pkg::*;

  logic [31:0] head_q, head_d, head_nx;
  logic [31:0] tail_q, tail_d, tail_nx;

  // combine stage one: final accumulators
  logic        s1_v_q;
  logic [31:0] s1_head_q, s1_tail_q, s1_len97_q;
  logic        s1_long_q, s1_mis_q;
  // combine stage two: length term added
  logic        s2_v_q;
  logic [31:0] s2_h_q, s2_tail_q;
  logic        s2_long_q, s2_mis_q;
  // output register
  logic        out_v_q;
  logic [31:0] out_fp_q;
  logic        out_mis_q;

  logic out_ready, s2_ready, s1_ready;
  logic s1_load, s2_load, out_load;

  assign out_ready = !out_v_q || !out_stall_i;
  assign s2_ready  = !s2_v_q || out_ready;
  assign s1_ready  = !s1_v_q || s2_ready;
  assign out_load  = s2_v_q && out_ready;
  assign s2_load   = s1_v_q && s2_ready;

  assign q_pop_o = !q_empty_i && (!q_entry_i.last || s1_ready);
  assign s1_load = q_pop_o && q_entry_i.last;

  assign head_nx = q_entry_i.head_en ? fnv_step(head_q, q_entry_i.data) : head_q;
  assign tail_nx = q_entry_i.tail_en ? fnv_step(tail_q, q_entry_i.data) : tail_q;

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    if (q_pop_o) begin
      head_d = q_entry_i.last ? FNV_BASIS : head_nx;
      tail_d = q_entry_i.last ? FNV_BASIS : tail_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= FNV_BASIS;
      tail_q  <= FNV_BASIS;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      s1_v_q  <= s1_load || (s1_v_q && !s2_ready);
      s2_v_q  <= s2_load || (s2_v_q && !out_ready);
      out_v_q <= out_load || (out_v_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_head_q  <= head_nx;
      s1_tail_q  <= tail_nx;
      s1_len97_q <= q_entry_i.len97;
      s1_long_q  <= q_entry_i.is_long;
      s1_mis_q   <= q_entry_i.mismatch;
    end
    if (s2_load) begin
      s2_h_q    <= s1_len97_q + s1_head_q;
      s2_tail_q <= s1_tail_q;
      s2_long_q <= s1_long_q;
      s2_mis_q  <= s1_mis_q;
    end
    if (out_load) begin
      out_fp_q  <= s2_long_q ? mul97(s2_h_q) + s2_tail_q : s2_h_q;
      out_mis_q <= s2_mis_q;
    end
  end

  assign out_valid_o       = out_v_q;
  assign fingerprint_o     = out_fp_q;
  assign length_mismatch_o = out_mis_q;

  `VFH_ASSERT(a_acc_restart, s1_load |=> (head_q == FNV_BASIS && tail_q == FNV_BASIS),
              "accumulators not restarted after final beat")
  `VFH_ASSERT(a_s1_hold, (s1_v_q && !s2_ready) |=> (s1_v_q && $stable(s1_head_q)),
              "combine stage lost data while stalled")
  `VFH_ASSERT(a_out_hold,
              (out_v_q && out_stall_i) |=> (out_v_q && $stable(out_fp_q) && $stable(out_mis_q)),
              "stalled result changed")

endmodule

// ===== hw/rtl/value_fingerprint_hash.sv =====
// Value fingerprint hash top level. Takes one byte beat per cycle with no
// bubbles while in_stall_o is low: the front counts bytes and marks each one
// for the head segment, the tail segment or neither, and a four-entry queue
// feeds the back end, whose FNV-1a accumulators take one xor and one constant
// multiply per byte. The fingerprint and length mismatch flag leave through
// an output register: after the edge that takes the final beat they pass a
// queue slot, two combine stages and the output register, waiting longer
// while the result side stalls; a following value may stream in meanwhile.
// in_stall_o rises only when the queue fills because the result side is held off.
module value_fingerprint_hash #(
  parameter int unsigned SEGMENT_BYTES = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic [30:0] value_len_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] fingerprint_o,
  output logic        length_mismatch_o
);
  import vfh_pkg::*;

  vfh_entry_t push_entry, pop_entry;
  logic       q_push, q_pop, q_full, q_empty;

  vfh_front #(
    .SEGMENT_BYTES(SEGMENT_BYTES)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .byte_present_i(byte_present_i),
    .value_len_i   (value_len_i),
    .last_byte_i   (last_byte_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_entry_o     (push_entry)
  );

  vfh_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .entry_i(push_entry),
    .full_o (q_full),
    .pop_i  (q_pop),
    .entry_o(pop_entry),
    .empty_o(q_empty)
  );

  vfh_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_empty_i        (q_empty),
    .q_entry_i        (pop_entry),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .fingerprint_o    (fingerprint_o),
    .length_mismatch_o(length_mismatch_o)
  );

endmodule
